// ----- design/spci_pkg.sv -----
// ----------------------------------------------------------------------------
// spci_pkg
// Widths, register indexes, reset values and controller-to-datapath command
// types shared by the speed loop modules.
// ----------------------------------------------------------------------------
package spci_pkg;

    // Field widths (Q16.16 quantities are held only as wide as their range)
    localparam int SPEED_W    = 24;
    localparam int ACCEL_W    = 23;
    localparam int DT_W       = 17;
    localparam int GAIN_W     = 23;
    localparam int CEIL_W     = 22;
    localparam int ERR_W      = SPEED_W + 1;
    localparam int WORD_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int PROD_W     = GAIN_W + 1 + WORD_W;
    localparam int ACC_W      = 42;
    localparam int BOUND_W    = 31;

    // Shared divider
    localparam int DIV_NUM_W  = 41;
    localparam int DIV_DEN_W  = 23;
    localparam int DIV_CNT_W  = 6;

    // Stream and configuration ports
    localparam int S_DATA_W   = 88;
    localparam int M_DATA_W   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    // Standstill thresholds: 0.05 m/s and 0.1 m/s
    localparam logic signed [SPEED_W-1:0] TARGET_NEAR_ZERO = 24'sd3276;
    localparam logic signed [SPEED_W-1:0] SPEED_NEAR_ZERO  = 24'sd6553;

    // Register reset values
    localparam logic [GAIN_W-1:0]          GAIN_P_RST     = 23'd65536;
    localparam logic [GAIN_W-1:0]          GAIN_I_RST     = 23'd0;
    localparam logic [GAIN_W-1:0]          GAIN_D_RST     = 23'd0;
    localparam logic [GAIN_W-1:0]          INT_LIMIT_RST  = 23'd65536;
    localparam logic signed [ACCEL_W-1:0]  ACCEL_FLOOR_RST = -23'sd327680;
    localparam logic [CEIL_W-1:0]          ACCEL_CEIL_RST = 22'd131072;
    localparam logic [CEIL_W-1:0]          HOLD_DECEL_RST = 22'd65536;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P      = 3'd0,
        CFG_GAIN_I      = 3'd1,
        CFG_GAIN_D      = 3'd2,
        CFG_INT_LIMIT   = 3'd3,
        CFG_ACCEL_FLOOR = 3'd4,
        CFG_ACCEL_CEIL  = 3'd5,
        CFG_HOLD_DECEL  = 3'd6
    } cfg_reg_t;

    // Operand pair of the shared multiplier
    typedef enum logic [1:0] {
        MUL_ERR_DT,
        MUL_P,
        MUL_I,
        MUL_D
    } mul_sel_t;

    // Accumulator operation
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_INIT,
        ACC_ADD
    } acc_op_t;

    // Which quotient the divider produces
    typedef enum logic {
        DIV_DERIV,
        DIV_BOUND
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     clear;
        logic     div_start;
        div_sel_t div_sel;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     prop_en;
        logic     clamp_en;
        logic     commit;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
    } dp_status_t;

endpackage

// ----- design/spci_div.sv -----
// ----------------------------------------------------------------------------
// spci_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spci_div
    import spci_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] dividend,
    input  logic [DIV_DEN_W-1:0] divisor,
    output logic [DIV_NUM_W-1:0] quotient,
    output logic                 done
);

    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_NUM_W - 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W-1:0] den_reg;

    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;
    logic [DIV_DEN_W-1:0] rem_next;
    logic [DIV_NUM_W-1:0] quo_next;

    // Shift in the next dividend bit and try the subtraction
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIV_NUM_W-1]};
        diff     = trial - {1'b0, den_reg};
        ge       = (trial >= {1'b0, den_reg});
        rem_next = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
        quo_next = {quo_reg[DIV_NUM_W-2:0], ge};
    end

    // Step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Partial remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ----- design/spci_datapath.sv -----
// ----------------------------------------------------------------------------
// spci_datapath
// Loop state, configuration registers, shared divider and multiplier,
// accumulator, clamps and the result register.
// ----------------------------------------------------------------------------
module spci_datapath
    import spci_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [M_DATA_W-1:0]   m_tdata
);

    localparam logic [DIV_NUM_W-1:0] Q_POS_MAX = DIV_NUM_W'(32'h7FFF_FFFF);
    localparam logic [DIV_NUM_W-1:0] Q_NEG_MAX = DIV_NUM_W'(32'h8000_0000);
    localparam int PAD_W = M_DATA_W - ACCEL_W - 2;

    // Configuration
    logic [GAIN_W-1:0]          gain_p_reg;
    logic [GAIN_W-1:0]          gain_i_reg;
    logic [GAIN_W-1:0]          gain_d_reg;
    logic [GAIN_W-1:0]          int_limit_reg;
    logic signed [ACCEL_W-1:0]  accel_floor_reg;
    logic [CEIL_W-1:0]          accel_ceil_reg;
    logic [CEIL_W-1:0]          hold_decel_reg;

    // Loop memory
    logic signed [WORD_W-1:0]   integral_reg;
    logic signed [SPEED_W-1:0]  prev_speed_reg;
    logic                       prev_valid_reg;

    // Working registers
    logic signed [SPEED_W-1:0]  speed_reg;
    logic signed [SPEED_W-1:0]  target_reg;
    logic signed [ACCEL_W-1:0]  ff_reg;
    logic [DT_W-1:0]            dt_reg;
    logic signed [ERR_W-1:0]    err_reg;
    div_sel_t                   div_sel_reg;
    logic signed [WORD_W-1:0]   deriv_reg;
    logic [BOUND_W-1:0]         bound_reg;
    logic signed [WORD_W-1:0]   prop_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACCEL_W-1:0]  res_cmd_reg;
    logic                       res_sat_reg;
    logic                       res_hold_reg;
    logic signed [ACCEL_W-1:0]  out_cmd_reg;
    logic                       out_sat_reg;
    logic                       out_hold_reg;

    // Input unpacking
    logic signed [SPEED_W-1:0]  in_speed;
    logic signed [SPEED_W-1:0]  in_target;
    logic signed [ACCEL_W-1:0]  in_ff;
    logic [DT_W-1:0]            in_dt;
    logic signed [ERR_W-1:0]    in_err;

    assign in_speed  = s_tdata[SPEED_W-1:0];
    assign in_target = s_tdata[2*SPEED_W-1:SPEED_W];
    assign in_ff     = s_tdata[2*SPEED_W+ACCEL_W-1:2*SPEED_W];
    assign in_dt     = s_tdata[2*SPEED_W+ACCEL_W+DT_W-1:2*SPEED_W+ACCEL_W];
    assign in_err    = ERR_W'(in_target) - ERR_W'(in_speed);

    // Divider operands and quotient handling
    logic signed [ERR_W-1:0]    speed_diff;
    logic [ERR_W-1:0]           diff_mag;
    logic [DIV_NUM_W-1:0]       div_dividend;
    logic [DIV_DEN_W-1:0]       div_divisor;
    logic [DIV_NUM_W-1:0]       div_quo;
    logic                       div_done;
    logic signed [WORD_W-1:0]   deriv_val;
    logic [BOUND_W-1:0]         bound_val;

    assign speed_diff = ERR_W'(prev_speed_reg) - ERR_W'(speed_reg);
    assign diff_mag   = speed_diff[ERR_W-1] ? ERR_W'(-speed_diff) : ERR_W'(speed_diff);

    always_comb
    begin
        if (cmd.div_sel == DIV_DERIV)
        begin
            div_dividend = {diff_mag, {FRAC_W{1'b0}}};
            div_divisor  = DIV_DEN_W'(dt_reg);
        end
        else
        begin
            div_dividend = DIV_NUM_W'({int_limit_reg, {FRAC_W{1'b0}}});
            div_divisor  = gain_i_reg;
        end
    end

    spci_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .done     (div_done)
    );

    assign status.div_done = div_done;

    // Sign and saturate the quotients
    always_comb
    begin
        if (!prev_valid_reg || (dt_reg == '0))
            deriv_val = '0;
        else if (speed_diff[ERR_W-1])
            deriv_val = (div_quo > Q_NEG_MAX) ? WORD_W'(Q_NEG_MAX)
                                              : WORD_W'(-div_quo);
        else
            deriv_val = (div_quo > Q_POS_MAX) ? WORD_W'(Q_POS_MAX)
                                              : WORD_W'(div_quo);

        if (gain_i_reg == '0)
            bound_val = '0;
        else if (div_quo > Q_POS_MAX)
            bound_val = BOUND_W'(Q_POS_MAX);
        else
            bound_val = div_quo[BOUND_W-1:0];
    end

    // Shared multiplier: unsigned gain by signed word
    logic signed [GAIN_W:0]     mul_a;
    logic signed [WORD_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [ACC_W-1:0]    prod_floor;

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_ERR_DT:
            begin
                mul_a = (GAIN_W+1)'(dt_reg);
                mul_b = WORD_W'(err_reg);
            end
            MUL_P:
            begin
                mul_a = {1'b0, gain_p_reg};
                mul_b = WORD_W'(err_reg);
            end
            MUL_I:
            begin
                mul_a = {1'b0, gain_i_reg};
                mul_b = prop_reg;
            end
            MUL_D:
            begin
                mul_a = {1'b0, gain_d_reg};
                mul_b = deriv_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next  = mul_a * mul_b;
    assign prod_floor = ACC_W'($signed(prod_reg[PROD_W-1:FRAC_W]));

    // Proposed integral, clamped to the symmetric bound
    logic signed [DIV_NUM_W-1:0] int_sum;
    logic signed [DIV_NUM_W-1:0] bnd_pos;
    logic signed [DIV_NUM_W-1:0] bnd_neg;
    logic signed [DIV_NUM_W-1:0] int_clamped;

    always_comb
    begin
        int_sum = DIV_NUM_W'(integral_reg)
                + DIV_NUM_W'($signed(prod_reg[PROD_W-1:FRAC_W]));
        bnd_pos = DIV_NUM_W'(bound_reg);
        bnd_neg = -bnd_pos;
        if (int_sum > bnd_pos)
            int_clamped = bnd_pos;
        else if (int_sum < bnd_neg)
            int_clamped = bnd_neg;
        else
            int_clamped = int_sum;
    end

    // Command clamp, saturation flag and standstill hold
    logic signed [ACC_W-1:0]    lim_lo;
    logic signed [ACC_W-1:0]    lim_hi;
    logic signed [ACC_W-1:0]    lim_hold;
    logic signed [ACC_W-1:0]    clamp_lo;
    logic signed [ACC_W-1:0]    clamp_hi;
    logic signed [ACC_W-1:0]    cmd_final;
    logic                       err_pos;
    logic                       err_neg;
    logic                       sat_val;
    logic                       hold_val;

    always_comb
    begin
        lim_lo   = ACC_W'(accel_floor_reg);
        lim_hi   = ACC_W'(accel_ceil_reg);
        lim_hold = -ACC_W'(hold_decel_reg);
        clamp_lo = (acc_reg < lim_lo) ? lim_lo : acc_reg;
        clamp_hi = (clamp_lo > lim_hi) ? lim_hi : clamp_lo;
        err_pos  = !err_reg[ERR_W-1] && (err_reg != '0);
        err_neg  = err_reg[ERR_W-1];
        sat_val  = ((clamp_hi < acc_reg) && err_pos) || ((clamp_hi > acc_reg) && err_neg);
        hold_val = (target_reg <= TARGET_NEAR_ZERO) && (speed_reg <= SPEED_NEAR_ZERO);
        cmd_final = (hold_val && (clamp_hi > lim_hold)) ? lim_hold : clamp_hi;
    end

    // Configuration writes and loop memory
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg      <= GAIN_P_RST;
            gain_i_reg      <= GAIN_I_RST;
            gain_d_reg      <= GAIN_D_RST;
            int_limit_reg   <= INT_LIMIT_RST;
            accel_floor_reg <= ACCEL_FLOOR_RST;
            accel_ceil_reg  <= ACCEL_CEIL_RST;
            hold_decel_reg  <= HOLD_DECEL_RST;
            integral_reg    <= '0;
            prev_speed_reg  <= '0;
            prev_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GAIN_P:      gain_p_reg      <= cfg_data;
                    CFG_GAIN_I:      gain_i_reg      <= cfg_data;
                    CFG_GAIN_D:      gain_d_reg      <= cfg_data;
                    CFG_INT_LIMIT:   int_limit_reg   <= cfg_data;
                    CFG_ACCEL_FLOOR: accel_floor_reg <= cfg_data;
                    CFG_ACCEL_CEIL:  accel_ceil_reg  <= cfg_data[CEIL_W-1:0];
                    CFG_HOLD_DECEL:  hold_decel_reg  <= cfg_data[CEIL_W-1:0];
                    default:         ;
                endcase
            end

            if (cmd.clear)
            begin
                integral_reg   <= '0;
                prev_speed_reg <= '0;
                prev_valid_reg <= 1'b0;
            end
            else if (cmd.commit)
            begin
                prev_speed_reg <= speed_reg;
                prev_valid_reg <= 1'b1;
                if (res_hold_reg)
                    integral_reg <= '0;
                else if (!res_sat_reg)
                    integral_reg <= prop_reg;
            end
        end
    end

    // Working registers of one control step
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            speed_reg  <= in_speed;
            target_reg <= in_target;
            ff_reg     <= in_ff;
            dt_reg     <= in_dt;
            err_reg    <= in_err;
        end

        if (cmd.div_start)
            div_sel_reg <= cmd.div_sel;

        if (div_done)
        begin
            if (div_sel_reg == DIV_DERIV)
                deriv_reg <= deriv_val;
            else
                bound_reg <= bound_val;
        end

        prod_reg <= prod_next;

        if (cmd.prop_en)
            prop_reg <= int_clamped[WORD_W-1:0];

        case (cmd.acc_op)
            ACC_INIT: acc_reg <= ACC_W'(ff_reg);
            ACC_ADD:  acc_reg <= acc_reg + prod_floor;
            default:  ;
        endcase

        if (cmd.clamp_en)
        begin
            res_cmd_reg  <= cmd_final[ACCEL_W-1:0];
            res_sat_reg  <= sat_val;
            res_hold_reg <= hold_val;
        end

        if (cmd.commit)
        begin
            out_cmd_reg  <= res_cmd_reg;
            out_sat_reg  <= res_sat_reg;
            out_hold_reg <= res_hold_reg;
        end
    end

    assign m_tdata = {{PAD_W{1'b0}}, out_hold_reg, out_sat_reg, out_cmd_reg};

endmodule

// ----- design/spci_ctrl.sv -----
// ----------------------------------------------------------------------------
// spci_ctrl
// Step sequencer: accepts requests, runs the two divisions and the
// multiply-accumulate sequence, and owns the output valid flag.
// ----------------------------------------------------------------------------
module spci_ctrl
    import spci_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tuser,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIVD_START,
        ST_DIVD_WAIT,
        ST_DIVB_START,
        ST_DIVB_WAIT,
        ST_MUL_E,
        ST_PROP,
        ST_MUL_I,
        ST_MUL_D,
        ST_ACC,
        ST_CLAMP,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    // Decode commands and the next state
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.div_sel   = DIV_DERIV;
        cmd.mul_sel   = MUL_ERR_DT;
        cmd.acc_op    = ACC_HOLD;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load  = !s_tuser;
                    cmd.clear = s_tuser;
                    state_next = s_tuser ? ST_IDLE : ST_DIVD_START;
                end
            end
            ST_DIVD_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_DERIV;
                state_next    = ST_DIVD_WAIT;
            end
            ST_DIVD_WAIT:
            begin
                if (status.div_done)
                    state_next = ST_DIVB_START;
            end
            ST_DIVB_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_BOUND;
                state_next    = ST_DIVB_WAIT;
            end
            ST_DIVB_WAIT:
            begin
                if (status.div_done)
                    state_next = ST_MUL_E;
            end
            ST_MUL_E:
            begin
                cmd.mul_sel = MUL_ERR_DT;
                state_next  = ST_PROP;
            end
            ST_PROP:
            begin
                cmd.prop_en = 1'b1;
                cmd.mul_sel = MUL_P;
                cmd.acc_op  = ACC_INIT;
                state_next  = ST_MUL_I;
            end
            ST_MUL_I:
            begin
                cmd.mul_sel = MUL_I;
                cmd.acc_op  = ACC_ADD;
                state_next  = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                cmd.mul_sel = MUL_D;
                cmd.acc_op  = ACC_ADD;
                state_next  = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc_op = ACC_ADD;
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                cmd.clamp_en = 1'b1;
                state_next   = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // State and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- design/speed_pid_conditional_integration_top.sv -----
// ----------------------------------------------------------------------------
// speed_pid_conditional_integration_top
// Speed loop PID with conditional-integration anti-windup, Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries requests: tuser = 0 for a control step, 1 to clear the loop
//   memory (integral and previous speed). A control step returns one result
//   on m_*; a clear returns none.
//   cfg_* writes the seven loop registers by index; it is always ready. The
//   user writes it only while no step is in flight; the block does not enforce it.
//   A control step runs the single one-bit-per-cycle divider for 41 steps
//   for the speed derivative and 41 steps for the integral bound, then the
//   shared multiplier in four passes and the clamp. One step is in flight
//   at a time: a new request is accepted only once the previous step has
//   committed its result.
//   A finished result sits in the output register; the next request is
//   accepted meanwhile, and its result waits in the sequencer until the
//   receiver takes the previous one.
//   Reset clears the loop memory, restores register defaults and drops
//   m_tvalid.
// ----------------------------------------------------------------------------
module speed_pid_conditional_integration_top
    import spci_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [23:0] measured_speed, [47:24] target_speed,
    // [70:48] feedforward_accel, [87:71] time_step
    input  logic [S_DATA_W-1:0]   s_tdata,
    // [0] opcode
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [22:0] accel_command, [23] output_saturated, [24] standstill_hold,
    // [31:25] zero
    output logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    spci_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    spci_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata)
    );

endmodule

// ----- design/spci_checker.sv -----
// ----------------------------------------------------------------------------
// spci_checker
// Port-level checks of the speed loop, bound to the top level.
// ----------------------------------------------------------------------------
module spci_checker
    import spci_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_DATA_W-1:0]   m_tdata
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed or dropped");

    // Standstill hold never leaves a positive command
    a_hold_brakes: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[ACCEL_W+1]) |->
        (m_tdata[ACCEL_W-1] || (m_tdata[ACCEL_W-1:0] == '0)))
        else $error("standstill hold with positive command");

    // A control step keeps the input closed in the next cycle
    a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tuser) |=> !s_tready)
        else $error("request accepted during a control step");

    // A clear request produces no result
    a_clear_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser && !m_tvalid) |=> !m_tvalid)
        else $error("clear request produced a result");

    // Leave reset with no result pending
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result valid out of reset");

endmodule

bind speed_pid_conditional_integration_top spci_checker u_spci_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the speed loop PID. A directed script covers field
// extremes, both operations, the standstill hold, clears, zero time step,
// floor above ceiling and an ignored register index. Random phases then run
// coherent speed trajectories with noise, under several register settings and
// source/sink idling patterns, all checked against an in-bench loop model.
// ----------------------------------------------------------------------------
module tb
    import spci_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    localparam int SAT_BIT          = ACCEL_W;
    localparam int HOLD_BIT         = ACCEL_W + 1;
    localparam int SETTLE_CYCLES    = 200;
    localparam int LONG_HOLD_CYCLES = 600;
    localparam int CYCLE_LIMIT      = 1000000;
    localparam int MAX_PRINTED      = 40;

    localparam int SPEED_MAX = 6553600;
    localparam int ACCEL_MAX = 3276800;
    localparam int GAIN_MAX  = 6553600;
    localparam int DT_MAX    = 65536;
    localparam int DT_TICK   = 3277;

    typedef struct packed {
        logic                      op;
        logic signed [SPEED_W-1:0] speed;
        logic signed [SPEED_W-1:0] target;
        logic signed [ACCEL_W-1:0] fwd;
        logic [DT_W-1:0]           dt;
    } loop_req_t;

    typedef struct packed {
        logic signed [ACCEL_W-1:0] accel;
        logic                      sat;
        logic                      hold;
    } loop_cmd_t;

    typedef enum logic [1:0] {
        ROW_STEP,
        ROW_CLEAR,
        ROW_REG
    } row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        int        speed;
        int        target;
        int        fwd;
        int        dt;
        int        typed;
        int        want_accel;
        int        want_sat;
        int        want_hold;
        int        idx;
        int        value;
    } script_row_t;

    localparam int SCRIPT_LEN = 22;

    // Directed script; typed expectations hold for the register values in force at their row
    script_row_t script_rows [SCRIPT_LEN] = '{
        '{ROW_STEP, 0, 0, 0, 65536, 1, -65536, 0, 1, 0, 0},
        '{ROW_STEP, 6553600, 6553600, 3276800, 65536, 1, 131072, 0, 0, 0, 0},
        '{ROW_STEP, -6553600, 6553600, 0, 0, 1, 131072, 1, 0, 0, 0},
        '{ROW_STEP, 6553600, -6553600, -3276800, 65536, 1, -327680, 1, 0, 0, 0},
        '{ROW_CLEAR, -6553600, 6553600, 3276800, 65536, 0, 0, 0, 0, 0, 0},
        '{ROW_STEP, 6553, 3276, 3276800, 0, 1, -65536, 0, 1, 0, 0},
        '{ROW_STEP, 6554, 3276, 0, 65535, 1, -3278, 0, 0, 0, 0},
        '{ROW_STEP, 0, 3277, 0, 0, 1, 3277, 0, 0, 0, 0},
        '{ROW_STEP, -6553600, -6553600, -3276800, 65536, 1, -327680, 0, 1, 0, 0},
        '{ROW_REG, 0, 0, 0, 0, 0, 0, 0, 0, CFG_UNUSED_IDX, 8388607},
        '{ROW_REG, 0, 0, 0, 0, 0, 0, 0, 0, CFG_GAIN_I, 6553},
        '{ROW_REG, 0, 0, 0, 0, 0, 0, 0, 0, CFG_GAIN_D, 32768},
        '{ROW_STEP, 100000, 200000, 0, 3277, 0, 0, 0, 0, 0, 0},
        '{ROW_STEP, 150000, 200000, 0, 3277, 0, 0, 0, 0, 0, 0},
        '{ROW_STEP, 180000, 200000, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_STEP, 190000, 200000, 0, 3277, 0, 0, 0, 0, 0, 0},
        '{ROW_REG, 0, 0, 0, 0, 0, 0, 0, 0, CFG_ACCEL_FLOOR, 65536},
        '{ROW_REG, 0, 0, 0, 0, 0, 0, 0, 0, CFG_ACCEL_CEIL, 0},
        '{ROW_STEP, 0, 655360, 0, 3277, 1, 0, 1, 0, 0, 0},
        '{ROW_STEP, -100000, -655360, 0, 3277, 0, 0, 0, 0, 0, 0},
        '{ROW_STEP, 5592405, -5592406, 2796202, 43690, 0, 0, 0, 0, 0, 0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Loop model state and register copy
    longint                    integ;
    longint                    prev_speed;
    bit                        prev_valid;
    logic [GAIN_W-1:0]         kp;
    logic [GAIN_W-1:0]         ki;
    logic [GAIN_W-1:0]         kd;
    logic [GAIN_W-1:0]         int_limit;
    logic signed [ACCEL_W-1:0] floor_reg;
    logic [CEIL_W-1:0]         ceil_reg;
    logic [CEIL_W-1:0]         hold_reg;

    loop_cmd_t pending_commands [$];

    int  tx_idle_pct;
    int  rx_stall_pct;
    bit  long_hold_req;
    bit  hold_active;
    int  cycles;
    int  mismatches;
    int  steps_sent;
    int  clears_sent;
    int  commands_checked;
    int  reg_writes;
    int  traj_speed;
    int  traj_target;
    int  traj_dt;

    speed_pid_conditional_integration_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 50 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int rand_span(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("mismatch on %s at cycle %0d: got %0d, expected %0d",
                     field, cycles, got, want);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_GAIN_P:      kp = val;
            CFG_GAIN_I:      ki = val;
            CFG_GAIN_D:      kd = val;
            CFG_INT_LIMIT:   int_limit = val;
            CFG_ACCEL_FLOOR: floor_reg = val;
            CFG_ACCEL_CEIL:  ceil_reg = val[CEIL_W-1:0];
            CFG_HOLD_DECEL:  hold_reg = val[CEIL_W-1:0];
            default:         ;
        endcase
    endtask

    // Loop model: one control step or clear, in 64-bit arithmetic
    task automatic compute_command(input loop_req_t rq, output bit produced,
                                   output loop_cmd_t cmd);
        longint spd, tgt, fwd, dt, err, deriv, bound, proposed, accel, lo, hi, res;
        bit     sat, hold;
        produced = 1'b0;
        cmd = '0;
        if (rq.op == OP_CLEAR)
        begin
            integ = 0;
            prev_speed = 0;
            prev_valid = 1'b0;
            return;
        end
        spd = $signed(rq.speed);
        tgt = $signed(rq.target);
        fwd = $signed(rq.fwd);
        dt  = rq.dt;
        err = tgt - spd;

        // derivative on measured speed, truncated and held to 32 bits
        deriv = 0;
        if (prev_valid && dt > 0)
        begin
            deriv = ((prev_speed - spd) * 65536) / dt;
            if (deriv < -64'sd2147483648)
                deriv = -64'sd2147483648;
            if (deriv > 64'sd2147483647)
                deriv = 64'sd2147483647;
        end
        prev_speed = spd;
        prev_valid = 1'b1;

        // integral bound and proposed integral
        bound = 0;
        if (ki != '0)
        begin
            bound = (longint'(int_limit) << 16) / longint'(ki);
            if (bound > 64'sd2147483647)
                bound = 64'sd2147483647;
        end
        proposed = integ + ((err * dt) >>> 16);
        if (proposed < -bound)
            proposed = -bound;
        if (proposed > bound)
            proposed = bound;

        accel = fwd + ((longint'(kp) * err) >>> 16)
                    + ((longint'(ki) * proposed) >>> 16)
                    + ((longint'(kd) * deriv) >>> 16);

        // floor first, then ceiling, so the ceiling wins
        lo = floor_reg;
        hi = longint'(ceil_reg);
        res = accel;
        if (res < lo)
            res = lo;
        if (res > hi)
            res = hi;

        sat = (res < accel && err > 0) || (res > accel && err < 0);
        if (!sat)
            integ = proposed;

        hold = (rq.target <= TARGET_NEAR_ZERO) && (rq.speed <= SPEED_NEAR_ZERO);
        if (hold)
        begin
            integ = 0;
            if (res > -longint'(hold_reg))
                res = -longint'(hold_reg);
        end

        produced = 1'b1;
        cmd.accel = res[ACCEL_W-1:0];
        cmd.sat = sat;
        cmd.hold = hold;
    endtask

    // Offer one request, hold it until taken, then predict its command
    task automatic send_item(input loop_req_t rq, input bit typed, input loop_cmd_t typed_cmd);
        bit        produced;
        loop_cmd_t cmd;
        cfg_valid <= 1'b0;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rq.op;
        s_tdata  <= {rq.dt, rq.fwd, rq.target, rq.speed};
        do
            @(posedge clk);
        while (!s_tready);
        compute_command(rq, produced, cmd);
        if (produced)
            pending_commands.push_back(typed ? typed_cmd : cmd);
        if (rq.op == OP_CLEAR)
            clears_sent++;
        else
            steps_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        set_register(idx, val);
        reg_writes++;
    endtask

    // Drop requests, let every command arrive, then cover a trailing clear
    task automatic wait_drain();
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (pending_commands.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_settings(input int p, input int i, input int d, input int lim,
                                 input int flr, input int ceil, input int hold);
        wait_drain();
        write_reg(CFG_GAIN_P, CFG_DATA_W'(p));
        write_reg(CFG_GAIN_I, CFG_DATA_W'(i));
        write_reg(CFG_GAIN_D, CFG_DATA_W'(d));
        write_reg(CFG_INT_LIMIT, CFG_DATA_W'(lim));
        write_reg(CFG_ACCEL_FLOOR, CFG_DATA_W'(flr));
        write_reg(CFG_ACCEL_CEIL, CFG_DATA_W'(ceil));
        write_reg(CFG_HOLD_DECEL, CFG_DATA_W'(hold));
    endtask

    task automatic random_settings();
        load_settings(rand_span(0, 196608), rand_span(0, 65536), rand_span(0, 32768),
                      rand_span(0, 196608), rand_span(-ACCEL_MAX, 0),
                      rand_span(0, ACCEL_MAX), rand_span(0, 196608));
    endtask

    // Mostly a vehicle tracking its target; some noise requests and clears
    task automatic next_item(output loop_req_t rq);
        int roll;
        int delta;
        roll = $urandom_range(99);
        rq.op = OP_STEP;
        if (roll < 15)
        begin
            if (roll < 3)
                rq.op = OP_CLEAR;
            rq.speed  = SPEED_W'(rand_span(-SPEED_MAX, SPEED_MAX));
            rq.target = SPEED_W'(rand_span(-SPEED_MAX, SPEED_MAX));
            rq.fwd    = ACCEL_W'(rand_span(-ACCEL_MAX, ACCEL_MAX));
            rq.dt     = DT_W'($urandom_range(DT_MAX));
            return;
        end
        // new segment: fresh target and tick
        if ($urandom_range(9) == 0)
        begin
            if ($urandom_range(2) == 0)
                traj_target = rand_span(-4000, 4000);
            else
                traj_target = rand_span(-SPEED_MAX, SPEED_MAX);
            case ($urandom_range(5))
                0:       traj_dt = 0;
                1:       traj_dt = DT_MAX;
                2:       traj_dt = rand_span(1, DT_MAX);
                default: traj_dt = DT_TICK;
            endcase
        end
        delta = (traj_target - traj_speed) / 8 + rand_span(-20000, 20000);
        traj_speed = traj_speed + delta;
        if (traj_speed > SPEED_MAX)
            traj_speed = SPEED_MAX;
        if (traj_speed < -SPEED_MAX)
            traj_speed = -SPEED_MAX;
        rq.speed  = SPEED_W'(traj_speed);
        rq.target = SPEED_W'(traj_target);
        if ($urandom_range(9) == 0)
            rq.fwd = ACCEL_W'(rand_span(-ACCEL_MAX, ACCEL_MAX));
        else
            rq.fwd = ACCEL_W'(rand_span(-65536, 65536));
        rq.dt = DT_W'(traj_dt);
    endtask

    task automatic run_random(input int count, input int tx_pct, input int rx_pct);
        loop_req_t rq;
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (count)
        begin
            next_item(rq);
            send_item(rq, 1'b0, '0);
        end
    endtask

    // Long receiver hold-off: count the cycles, back the block up into its input
    initial
    begin
        hold_active = 1'b0;
        wait (long_hold_req);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    // Sink: check each accepted command, then pick the next ready level
    initial
    begin
        loop_cmd_t want;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (pending_commands.size() == 0)
                    report_mismatch("unexpected command", longint'(m_tdata), 0);
                else
                begin
                    want = pending_commands.pop_front();
                    commands_checked++;
                    if (m_tdata[ACCEL_W-1:0] !== want.accel)
                        report_mismatch("accel_command",
                                        longint'($signed(m_tdata[ACCEL_W-1:0])),
                                        longint'(want.accel));
                    if (m_tdata[SAT_BIT] !== want.sat)
                        report_mismatch("output_saturated", longint'(m_tdata[SAT_BIT]),
                                        longint'(want.sat));
                    if (m_tdata[HOLD_BIT] !== want.hold)
                        report_mismatch("standstill_hold", longint'(m_tdata[HOLD_BIT]),
                                        longint'(want.hold));
                    if (m_tdata[M_DATA_W-1:HOLD_BIT+1] !== '0)
                        report_mismatch("padding", longint'(m_tdata[M_DATA_W-1:HOLD_BIT+1]),
                                        0);
                end
            end
            // hold off while the long stall runs
            if (hold_active)
                m_tready <= 1'b0;
            else
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Watchdog
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb NOT OK");
        $finish;
    end

    // Stimulus
    initial
    begin
        loop_req_t   rq;
        loop_cmd_t   typed_cmd;
        script_row_t row;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        long_hold_req = 1'b0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        mismatches = 0;
        steps_sent = 0;
        clears_sent = 0;
        commands_checked = 0;
        reg_writes = 0;
        traj_speed = 0;
        traj_target = 0;
        traj_dt = DT_TICK;
        integ = 0;
        prev_speed = 0;
        prev_valid = 1'b0;
        kp = GAIN_P_RST;
        ki = GAIN_I_RST;
        kd = GAIN_D_RST;
        int_limit = INT_LIMIT_RST;
        floor_reg = ACCEL_FLOOR_RST;
        ceil_reg = ACCEL_CEIL_RST;
        hold_reg = HOLD_DECEL_RST;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed script
        for (int i = 0; i < SCRIPT_LEN; i++)
        begin
            row = script_rows[i];
            if (row.kind == ROW_REG)
            begin
                wait_drain();
                write_reg(CFG_IDX_W'(row.idx), CFG_DATA_W'(row.value));
            end
            else
            begin
                rq.op     = (row.kind == ROW_CLEAR) ? OP_CLEAR : OP_STEP;
                rq.speed  = SPEED_W'(row.speed);
                rq.target = SPEED_W'(row.target);
                rq.fwd    = ACCEL_W'(row.fwd);
                rq.dt     = DT_W'(row.dt);
                typed_cmd.accel = ACCEL_W'(row.want_accel);
                typed_cmd.sat   = (row.want_sat != 0);
                typed_cmd.hold  = (row.want_hold != 0);
                send_item(rq, row.typed != 0, typed_cmd);
            end
        end

        // random phases over register settings and idling patterns
        random_settings();
        run_random(300, 0, 0);
        load_settings(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, -ACCEL_MAX, ACCEL_MAX, ACCEL_MAX);
        run_random(200, 79, 0);
        load_settings(65536, 1, 3277, GAIN_MAX, -ACCEL_MAX, ACCEL_MAX, 65536);
        run_random(250, 0, 79);
        load_settings(0, 0, 0, 0, 0, 0, 0);
        run_random(150, 24, 24);
        load_settings(131072, 6553, 0, 65536, 65536, 0, 0);
        run_random(100, 0, 0);
        random_settings();
        long_hold_req <= 1'b1;
        run_random(300, 0, 79);
        random_settings();
        run_random(250, 24, 24);

        wait_drain();
        $display("run: %0d control steps and %0d clears sent, %0d commands checked",
                 steps_sent, clears_sent, commands_checked);
        $display("     %0d register writes across several settings, with idle, stall and hold-off phases",
                 reg_writes);
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/spci_pkg.sv
design/spci_div.sv
design/spci_datapath.sv
design/spci_ctrl.sv
design/speed_pid_conditional_integration_top.sv
design/spci_checker.sv
bench/tb.sv
